[src/hsfc_pkg.sv]
package hsfc_pkg;

    // opcode values
    localparam logic OP_S2H = 1'b0;
    localparam logic OP_H2S = 1'b1;

    // operand class found in the decode stage
    typedef enum logic [2:0] {
        K_ZERO,
        K_INF,
        K_NAN,
        K_SUB,
        K_NORM
    } t_kind;

    localparam logic [15:0] HALF_INF   = 16'h7C00;
    localparam logic [15:0] HALF_NAN   = 16'hFE00;
    localparam logic [31:0] SINGLE_INF = 32'h7F80_0000;
    localparam logic [7:0]  EXP_MAX    = 8'hFF;
    localparam logic [4:0]  HEXP_MAX   = 5'h1F;

    // single exponent bounds for the half ranges
    localparam logic [7:0]  E8_OVF     = 8'd143;
    localparam logic [7:0]  E8_SUB_HI  = 8'd112;
    localparam logic [7:0]  E8_SUB_LO  = 8'd102;
    localparam logic [7:0]  SUB_SH_REF = 8'd126;
    localparam logic [7:0]  BIAS_DIFF  = 8'd112;
    localparam logic [7:0]  DENORM_E8  = 8'd113;

endpackage

[src/hsfc_in_if.sv]
interface hsfc_in_if;
    logic        valid;
    logic        ready;
    logic        opcode;
    logic [31:0] operand;

    modport source (output valid, output opcode, output operand, input ready);
    modport sink   (input valid, input opcode, input operand, output ready);
endinterface

[src/hsfc_out_if.sv]
interface hsfc_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] converted;

    modport source (output valid, output converted, input ready);
    modport sink   (input valid, input converted, output ready);
endinterface

[src/half_single_float_convert_top.sv]
// Stages from input accept to result valid, in order: decode, shift/pack, round.
// Throughput: one item per cycle; each stage holds one item and advances when
// the stage after it is empty or moving, so a stall at the output backs up in order.
// Reset: synchronous, active low; clears the three stage valid bits only.
// No state is kept between items.
module half_single_float_convert_top
    import hsfc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    hsfc_in_if.sink           i_in,
    hsfc_out_if.source        o_out
);

    // ---------------------------------------------------------------
    // Stage handshake: a stage loads when it is empty or its item leaves
    // ---------------------------------------------------------------
    logic r1_valid, r2_valid, r3_valid;
    logic ld1, ld2, ld3;

    assign ld3 = !r3_valid || o_out.ready;
    assign ld2 = !r2_valid || ld3;
    assign ld1 = !r1_valid || ld2;

    assign i_in.ready = ld1;

    // ---------------------------------------------------------------
    // Stage 1: classify the operand, leading-one search for half denormals
    // ---------------------------------------------------------------
    logic        r1_op, n1_op;
    logic        r1_sgn, n1_sgn;
    t_kind       r1_kind, n1_kind;
    logic [4:0]  r1_sh, n1_sh;
    logic [7:0]  r1_exp, n1_exp;
    logic [22:0] r1_man, n1_man;

    logic [7:0]  e8;
    logic [4:0]  he;
    logic [9:0]  hm;
    logic [3:0]  msb;
    logic [3:0]  lz_sh;
    logic [7:0]  sub_sh;

    always_comb begin
        e8     = i_in.operand[30:23];
        he     = i_in.operand[14:10];
        hm     = i_in.operand[9:0];
        sub_sh = SUB_SH_REF - e8;

        // highest set bit of the half mantissa
        msb = 4'd0;
        for (int b = 1; b < 10; b++) begin
            if (hm[b]) begin
                msb = 4'(b);
            end
        end
        lz_sh = 4'd10 - msb;

        n1_op   = i_in.opcode;
        n1_kind = K_ZERO;
        n1_sh   = 5'd0;
        n1_exp  = 8'd0;

        if (i_in.opcode == OP_S2H) begin
            n1_sgn = i_in.operand[31];
            n1_man = i_in.operand[22:0];
            if (e8 == 8'd0) begin
                n1_kind = K_ZERO;           // zero and single denormals
            end else if (e8 == EXP_MAX) begin
                n1_kind = (n1_man == 23'd0) ? K_INF : K_NAN;
            end else if (e8 >= E8_OVF) begin
                n1_kind = K_INF;
            end else if (e8 <= E8_SUB_HI) begin
                if (e8 >= E8_SUB_LO) begin
                    n1_kind = K_SUB;        // shift of 14 to 24
                    n1_sh   = sub_sh[4:0];
                end else begin
                    n1_kind = K_ZERO;       // deep underflow
                end
            end else begin
                n1_kind = K_NORM;
                n1_exp  = e8 - BIAS_DIFF;
            end
        end else begin
            n1_sgn = i_in.operand[15];
            n1_man = {13'd0, hm};
            if (i_in.operand[14:0] == 15'd0) begin
                n1_kind = K_ZERO;
            end else if (he == 5'd0) begin
                n1_kind = K_SUB;
                n1_sh   = {1'b0, lz_sh};
                n1_exp  = DENORM_E8 - {4'd0, lz_sh};
            end else if (he == HEXP_MAX) begin
                n1_kind = (hm == 10'd0) ? K_INF : K_NAN;
            end else begin
                n1_kind = K_NORM;
                n1_exp  = {3'd0, he} + BIAS_DIFF;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (ld1) begin
            r1_valid <= i_in.valid;
        end
        if (ld1) begin
            r1_op   <= n1_op;
            r1_sgn  <= n1_sgn;
            r1_kind <= n1_kind;
            r1_sh   <= n1_sh;
            r1_exp  <= n1_exp;
            r1_man  <= n1_man;
        end
    end

    // ---------------------------------------------------------------
    // Stage 2: denormal shifts and field packing, round bit picked out
    // ---------------------------------------------------------------
    logic        r2_op;
    logic        r2_rnd, n2_rnd;
    logic [31:0] r2_base, n2_base;

    logic [23:0] full;
    logic [23:0] shr;
    logic [23:0] shr_m1;
    logic [4:0]  sh_m1;
    logic [9:0]  m_norm;

    always_comb begin
        full   = {1'b1, r1_man};
        sh_m1  = r1_sh - 5'd1;
        shr    = full >> r1_sh;
        shr_m1 = full >> sh_m1;
        m_norm = r1_man[9:0] << r1_sh[3:0];
        n2_rnd = 1'b0;

        if (r1_op == OP_S2H) begin
            case (r1_kind)
                K_ZERO: n2_base = {16'd0, r1_sgn, 15'd0};
                K_INF:  n2_base = {16'd0, r1_sgn, HALF_INF[14:0]};
                K_NAN:  n2_base = {16'd0, HALF_NAN};
                K_SUB: begin
                    n2_base = {16'd0, r1_sgn, 5'd0, shr[9:0]};
                    n2_rnd  = shr_m1[0];
                end
                K_NORM: begin
                    n2_base = {16'd0, r1_sgn, r1_exp[4:0], r1_man[22:13]};
                    n2_rnd  = r1_man[12];
                end
                default: n2_base = 32'd0;
            endcase
        end else begin
            case (r1_kind)
                K_ZERO:  n2_base = {r1_sgn, 31'd0};
                K_INF:   n2_base = {r1_sgn, SINGLE_INF[30:0]};
                K_NAN:   n2_base = 32'd0;       // half NaN maps to +0.0
                K_SUB:   n2_base = {r1_sgn, r1_exp, m_norm, 13'd0};
                K_NORM:  n2_base = {r1_sgn, r1_exp, r1_man[9:0], 13'd0};
                default: n2_base = 32'd0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (ld2) begin
            r2_valid <= r1_valid;
        end
        if (ld2) begin
            r2_op   <= r1_op;
            r2_rnd  <= n2_rnd;
            r2_base <= n2_base;
        end
    end

    // ---------------------------------------------------------------
    // Stage 3: round half results half up, single results pass through; a mantissa carry runs into the exponent
    // ---------------------------------------------------------------
    logic        r3_op;
    logic [31:0] r3_res, n3_res;

    always_comb begin
        if (r2_op == OP_S2H) begin
            n3_res = {16'd0, r2_base[15:0] + {15'd0, r2_rnd}};
        end else begin
            n3_res = r2_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
        end else if (ld3) begin
            r3_valid <= r2_valid;
        end
        if (ld3) begin
            r3_op  <= r2_op;
            r3_res <= n3_res;
        end
    end

    assign o_out.valid     = r3_valid;
    assign o_out.converted = r3_res;

`ifndef SYNTHESIS
    // input is refused only when every stage is full
    a_full_backpressure: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !i_in.ready |-> (r1_valid && r2_valid && r3_valid)
    ) else $error("input stalled with an empty stage");

    // a stalled output keeps the item behind it in stage 2
    a_stage2_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r2_valid && r3_valid && !o_out.ready) |=> (r2_valid && $stable(r2_base))
    ) else $error("stage 2 item lost under stall");

    // half results never carry upper bits
    a_half_upper_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r3_valid && r3_op == OP_S2H) |-> (r3_res[31:16] == 16'd0)
    ) else $error("half result has upper bits set");
`endif

endmodule

[test/half_single_float_convert_checker.sv]
`timescale 1ns / 1ps

module half_single_float_convert_checker
    import hsfc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic        i_in_opcode,
    input  logic [31:0] i_in_operand,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_out_converted,
    output int          o_fail_count,
    output int          o_pending
);

    logic [31:0] converted_due[$];
    logic [31:0] want;
    int          mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    // single -> half, round half up, carry may ripple into the exponent
    function automatic logic [15:0] narrow_to_half(input logic [31:0] x);
        logic        sgn;
        logic [7:0]  e8;
        logic [22:0] man;
        logic [23:0] full;
        logic [15:0] res;
        int          sh;
        sgn = x[31];
        e8  = x[30:23];
        man = x[22:0];
        if (x[30:0] == 31'd0 || e8 == 8'd0) begin
            res = {sgn, 15'd0};
        end else if (e8 == EXP_MAX) begin
            res = (man == 23'd0) ? {sgn, HALF_INF[14:0]} : HALF_NAN;
        end else if (e8 >= E8_OVF) begin
            res = {sgn, HALF_INF[14:0]};
        end else if (e8 <= E8_SUB_HI) begin
            // half denormal: shift, round up on the first dropped bit
            sh  = int'(SUB_SH_REF) - int'(e8);
            res = {sgn, 15'd0};
            if (sh <= 24) begin
                full = {1'b1, man};
                res  = res | 16'(full >> sh);
                if (full[sh - 1])
                    res = res + 16'd1;
            end
        end else begin
            res = {sgn, 5'(e8 - BIAS_DIFF), man[22:13]};
            if (man[12])
                res = res + 16'd1;
        end
        return res;
    endfunction

    // half -> single, exact; NaN collapses to +0.0
    function automatic logic [31:0] widen_to_single(input logic [15:0] h);
        logic [9:0]  hm;
        logic [9:0]  m;
        logic [7:0]  e8;
        logic [31:0] res;
        int          msb;
        int          sh;
        hm = h[9:0];
        if (h[14:0] == 15'd0) begin
            res = {h[15], 31'd0};
        end else if (h[14:10] == 5'd0) begin
            msb = 9;
            while (msb > 0 && !hm[msb])
                msb--;
            sh  = 10 - msb;
            e8  = DENORM_E8 - 8'(sh);
            m   = hm << sh;
            res = {h[15], e8, m, 13'd0};
        end else if (h[14:10] == HEXP_MAX) begin
            res = (hm == 10'd0) ? {h[15], SINGLE_INF[30:0]} : 32'd0;
        end else begin
            res = {h[15], 8'(h[14:10]) + BIAS_DIFF, hm, 13'd0};
        end
        return res;
    endfunction

    function automatic logic [31:0] convert_pattern(input logic op, input logic [31:0] val);
        if (op == OP_S2H)
            return {16'd0, narrow_to_half(val)};
        else
            return widen_to_single(val[15:0]);
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] exp_word);
        $display("[%0t] converter: %s: got %08h, expected %08h", $time, what, got, exp_word);
        mismatch_count++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready)
                converted_due.push_back(convert_pattern(i_in_opcode, i_in_operand));
            if (i_out_valid && i_out_ready) begin
                if (converted_due.size() == 0) begin
                    flag_mismatch("unexpected item", i_out_converted, 32'd0);
                end else begin
                    want = converted_due.pop_front();
                    if (i_out_converted !== want)
                        flag_mismatch("converted", i_out_converted, want);
                end
            end
        end
        o_pending <= converted_due.size();
    end

endmodule

[test/half_single_float_convert_top_tb.sv]
`timescale 1ns / 1ps

module half_single_float_convert_top_tb;
    import hsfc_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_ITEMS = 200;     // per idling phase

    logic i_clk = 1'b0;
    logic i_rst_n;

    // idle percentages: the chance that the sender or receiver idles in a given cycle
    int send_idle = 0;
    int recv_idle = 0;
    int cycles    = 0;
    int fail_count;
    int pending;

    hsfc_in_if  in_ch ();
    hsfc_out_if out_ch ();

    half_single_float_convert_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    // checker sits beside the block, watching both channels
    half_single_float_convert_checker u_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (in_ch.valid),
        .i_in_ready      (in_ch.ready),
        .i_in_opcode     (in_ch.opcode),
        .i_in_operand    (in_ch.operand),
        .i_out_valid     (out_ch.valid),
        .i_out_ready     (out_ch.ready),
        .i_out_converted (out_ch.converted),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hard stop if the pipeline hangs
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("half_single_float_convert_top: mismatch");
            $finish;
        end
    end

    // receiver back-pressure: one decision per edge, held low through reset
    always @(posedge i_clk) begin
        if (!i_rst_n)
            out_ch.ready <= 1'b0;
        else
            out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // present one item, with optional idle cycles in front, and hold it until taken
    task automatic send_item(input logic op, input logic [31:0] val);
        while ($urandom_range(99) < send_idle) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.opcode  <= op;
        in_ch.operand <= val;
        do
            @(posedge i_clk);
        while (in_ch.ready !== 1'b1);
    endtask

    // stop sending and let every outstanding conversion come back
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        do
            @(posedge i_clk);
        while (pending != 0);
        // the pipeline has three stages; the extra wait catches any stray item
        repeat (6) @(posedge i_clk);
    endtask

    // random single pattern, biased toward the interesting exponent bands
    function automatic logic [31:0] pick_single();
        logic [7:0]  e8;
        logic [22:0] man;
        logic        sgn;
        sgn = 1'($urandom_range(1));
        man = 23'($urandom());
        case ($urandom_range(9))
            0: return $urandom();
            1: begin
                e8 = 8'd0;
                if ($urandom_range(3) == 0) man = 23'd0;
            end
            2: begin
                e8 = EXP_MAX;
                if ($urandom_range(1) == 0) man = 23'd0;
            end
            3: e8 = 8'($urandom_range(E8_SUB_HI, E8_SUB_LO));  // half denormal band
            4: e8 = 8'($urandom_range(E8_SUB_LO - 1, 1));      // deep underflow
            5: begin
                e8  = 8'($urandom_range(E8_OVF - 1, E8_SUB_HI + 1));
                man = man | 23'h0000_1000;                     // force the round-up bit
            end
            6: e8 = 8'($urandom_range(EXP_MAX - 1, E8_OVF));   // overflow to infinity
            7: begin
                e8  = E8_OVF - 8'd1;
                man = 23'h7F_F000 | (man & 23'h00_0FFF);       // carry ripples to infinity
            end
            default: e8 = 8'($urandom_range(E8_OVF - 1, E8_SUB_LO));
        endcase
        return {sgn, e8, man};
    endfunction

    // random half pattern in the low bits; the upper bits are noise
    function automatic logic [31:0] pick_half();
        logic [31:0] w;
        w = $urandom();
        case ($urandom_range(3))
            0: w[14:10] = 5'd0;                                // zero or denormal
            1: begin
                w[14:10] = HEXP_MAX;
                if ($urandom_range(1) == 0) w[9:0] = 10'd0;
            end
            default: ;
        endcase
        return w;
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(1) == 0)
                send_item(OP_S2H, pick_single());
            else
                send_item(OP_H2S, pick_half());
        end
    endtask

    initial begin
        in_ch.valid   <= 1'b0;
        in_ch.opcode  <= OP_S2H;
        in_ch.operand <= 32'd0;
        i_rst_n       <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle = 38; recv_idle = 88; end
                1: begin send_idle = 88; recv_idle = 38; end
                default: begin send_idle = 0; recv_idle = 0; end
            endcase

            if (phase == 0) begin
                // single -> half corners
                send_item(OP_S2H, 32'h0000_0000);   // +0
                send_item(OP_S2H, 32'h8000_0000);   // -0
                send_item(OP_S2H, 32'h0000_0001);   // smallest denormal, flushed
                send_item(OP_S2H, 32'h807F_FFFF);   // largest negative denormal
                send_item(OP_S2H, 32'h7F80_0000);   // +inf
                send_item(OP_S2H, 32'hFF80_0000);   // -inf
                send_item(OP_S2H, 32'h7FC0_0000);   // quiet NaN
                send_item(OP_S2H, 32'hFFFF_FFFF);   // negative NaN, all payload bits
                send_item(OP_S2H, 32'hC780_0000);   // first overflowing exponent
                send_item(OP_S2H, 32'h477F_F000);   // rounds up into infinity
                send_item(OP_S2H, 32'h3F80_1000);   // 1.0 plus a half ulp, rounds up
                send_item(OP_S2H, 32'h3880_0000);   // smallest half normal
                send_item(OP_S2H, 32'h387F_FFFF);   // top of denormal band, rounds to normal
                send_item(OP_S2H, 32'hB300_0000);   // bottom of denormal band
                send_item(OP_S2H, 32'h3280_0000);   // deep underflow
                // half -> single corners
                send_item(OP_H2S, 32'h0000_0000);
                send_item(OP_H2S, 32'h0000_8000);   // -0
                send_item(OP_H2S, 32'h0000_0001);   // smallest half denormal
                send_item(OP_H2S, 32'h0000_83FF);   // largest negative denormal
                send_item(OP_H2S, 32'h0000_7C00);   // +inf
                send_item(OP_H2S, 32'h0000_FC00);   // -inf
                send_item(OP_H2S, 32'h0000_7E00);   // NaN
                send_item(OP_H2S, 32'hFFFF_FFFF);   // NaN, upper bits set
                send_item(OP_H2S, 32'hABCD_3C00);   // 1.0, upper bits ignored
                send_item(OP_H2S, 32'h0000_7BFF);   // largest half normal
            end

            send_random(RANDOM_ITEMS);
            // sender holds off here until every result is back
            drain_results();
        end

        if (fail_count == 0)
            $display("half_single_float_convert_top: match");
        else
            $display("half_single_float_convert_top: mismatch");
        $finish;
    end

endmodule
